// File: hdl/atan_pkg.sv
// atan_pkg: shared types and constants for the atan2 degrees pipeline.
// No dependencies.
package atan_pkg;

    localparam int IN_W  = 15;  // input sample width
    localparam int DEN_W = 16;  // divisor width, |x| + |y| <= 32768
    localparam int REM_W = 17;  // partial remainder width after the shift
    localparam int ANG_W = 9;   // result width

    localparam int C_LO    = 45;
    localparam int C_HI    = 135;
    localparam int C_R     = 56;
    localparam int C_CUBE  = 11;
    localparam int C_FULL  = 360;
    localparam int C_HALF  = 180;

    // item flags that ride along the pipeline
    typedef struct packed {
        logic vld;
        logic neg_r;
        logic y_zero;
        logic y_neg;
        logic x_neg;
    } t_side;

endpackage

// File: hdl/atan_dcell.sv
// atan_dcell: one restoring-division cell, one quotient bit per cell.
// Depends on atan_pkg.
module atan_dcell #(
    parameter int QW    = 9,
    parameter bit SHIFT = 1'b1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [atan_pkg::REM_W-1:0] i_rem,
    input  logic [atan_pkg::DEN_W-1:0] i_den,
    input  logic [QW-1:0]              i_quo,
    input  atan_pkg::t_side            i_side,
    output logic [atan_pkg::REM_W-1:0] o_rem,
    output logic [atan_pkg::DEN_W-1:0] o_den,
    output logic [QW-1:0]              o_quo,
    output atan_pkg::t_side            o_side
);

    logic [atan_pkg::REM_W-1:0] rs;
    logic [atan_pkg::REM_W-1:0] dz;
    logic                       ge;
    logic [atan_pkg::REM_W-1:0] n_rem;
    logic [QW-1:0]              n_quo;

    always_comb begin
        rs    = SHIFT ? {i_rem[atan_pkg::REM_W-2:0], 1'b0} : i_rem;
        dz    = {1'b0, i_den};
        ge    = (rs >= dz);
        n_rem = ge ? (rs - dz) : rs;
        n_quo = {i_quo[QW-2:0], ge};
    end

    logic [atan_pkg::REM_W-1:0] r_rem;
    logic [atan_pkg::DEN_W-1:0] r_den;
    logic [QW-1:0]              r_quo;
    atan_pkg::t_side            r_side;

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_den <= i_den;
        r_quo <= n_quo;
        if (!i_rst_n) begin
            r_side <= '0;
        end else begin
            r_side <= i_side;
        end
    end

    assign o_rem  = r_rem;
    assign o_den  = r_den;
    assign o_quo  = r_quo;
    assign o_side = r_side;

endmodule

// File: hdl/atan2_degrees_fixed_point.sv
// atan2_degrees_fixed_point: top level, vector angle in whole degrees.
// Depends on atan_pkg and atan_dcell.
//
// Usage:
//   Drive i_y_value / i_x_value and pulse start. busy is always low, so an
//   item is taken on every cycle that start is high: one item per cycle.
//   Each item yields exactly one result on o_angle_degrees (0..360), shown
//   for one cycle with o_done high. The receiver cannot stall; results
//   must be taken on the cycle they appear.
// Pipeline, in order from accept to o_done:
//   operand prep register (|y|, numerator and divisor)
//   F+1 cells restoring divider, one quotient bit per cell
//   r^2, r^3 and polynomial registers
//   quadrant fix-up, clamp, output register
// Throughput is set by the cell chain: every cell hands its partial
// remainder to the next each cycle, so a new item enters every cycle.
// Reset (synchronous, active low) clears all valid flags; items in flight
// are dropped. There is no configuration and no stored state.
module atan2_degrees_fixed_point #(
    parameter int FRAC_BITS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic signed [atan_pkg::IN_W-1:0] i_y_value,
    input  logic signed [atan_pkg::IN_W-1:0] i_x_value,
    output logic                            o_done,
    output logic [atan_pkg::ANG_W-1:0]      o_angle_degrees
);

    localparam int QW  = FRAC_BITS + 1;     // quotient bits, q <= 2^F
    localparam int RW  = FRAC_BITS + 2;     // signed ratio
    localparam int PW  = 2 * RW;            // product width
    localparam int SW  = RW + 8;            // polynomial sum width
    localparam int LAT = FRAC_BITS + 6;

    assign busy = 1'b0;

    // ---------------- operand prep ----------------
    logic signed [16:0] ys, xs, ya, num, den;
    logic [atan_pkg::DEN_W-1:0] nabs;
    atan_pkg::t_side n_side0;

    always_comb begin
        ys = 17'(i_y_value);
        xs = 17'(i_x_value);
        ya = ys[16] ? -ys : ys;
        if (!xs[16]) begin
            num = xs - ya;
            den = xs + ya;
        end else begin
            num = xs + ya;
            den = ya - xs;
        end
        nabs = num[16] ? atan_pkg::DEN_W'(-num) : atan_pkg::DEN_W'(num);
        n_side0.vld    = start;
        n_side0.neg_r  = num[16];
        n_side0.y_zero = (ys == 17'sd0);
        n_side0.y_neg  = ys[16];
        n_side0.x_neg  = xs[16];
    end

    logic [atan_pkg::REM_W-1:0] r_rem0;
    logic [atan_pkg::DEN_W-1:0] r_den0;
    atan_pkg::t_side            r_side0;

    always_ff @(posedge i_clk) begin
        r_rem0 <= {1'b0, nabs};
        r_den0 <= atan_pkg::DEN_W'(den);
        if (!i_rst_n) begin
            r_side0 <= '0;
        end else begin
            r_side0 <= n_side0;
        end
    end

    // ---------------- divider cell chain ----------------
    logic [atan_pkg::REM_W-1:0] c_rem [QW+1];
    logic [atan_pkg::DEN_W-1:0] c_den [QW+1];
    logic [QW-1:0]              c_quo [QW+1];
    atan_pkg::t_side            c_side[QW+1];

    assign c_rem[0]  = r_rem0;
    assign c_den[0]  = r_den0;
    assign c_quo[0]  = '0;
    assign c_side[0] = r_side0;

    for (genvar g = 0; g < QW; g++) begin : g_cell
        atan_dcell #(
            .QW    (QW),
            .SHIFT (g != 0)    // first cell yields the integer bit
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_rem   (c_rem[g]),
            .i_den   (c_den[g]),
            .i_quo   (c_quo[g]),
            .i_side  (c_side[g]),
            .o_rem   (c_rem[g+1]),
            .o_den   (c_den[g+1]),
            .o_quo   (c_quo[g+1]),
            .o_side  (c_side[g+1])
        );
    end

    // ---------------- polynomial ----------------
    logic signed [RW-1:0] rq;
    assign rq = c_side[QW].neg_r ? -$signed({1'b0, c_quo[QW]})
                                 :  $signed({1'b0, c_quo[QW]});

    // stage 1: r^2
    logic signed [RW-1:0] r_r1;
    logic signed [PW-1:0] r_sq;
    atan_pkg::t_side      r_side1;

    // stage 2: r^3
    logic signed [RW-1:0] r_r2;
    logic signed [PW-1:0] r_cu;
    atan_pkg::t_side      r_side2;
    logic signed [PW-1:0] sq_sh;

    // stage 3: t
    logic signed [SW-1:0] r_t;
    atan_pkg::t_side      r_side3;
    logic signed [PW-1:0] cu_sh;
    logic signed [SW-1:0] poly;

    always_comb begin
        sq_sh = r_sq >>> FRAC_BITS;
        cu_sh = r_cu >>> FRAC_BITS;
        // the cube term can be negative, keep its sign when widening
        poly  = SW'(r_r2) * SW'(-atan_pkg::C_R)
              + SW'($signed(cu_sh[RW-1:0])) * SW'(atan_pkg::C_CUBE);
    end

    always_ff @(posedge i_clk) begin
        r_r1 <= rq;
        r_sq <= PW'(rq) * PW'(rq);
        r_r2 <= r_r1;
        r_cu <= PW'(sq_sh[RW-1:0]) * PW'(r_r1);
        r_t  <= poly >>> FRAC_BITS;
        if (!i_rst_n) begin
            r_side1 <= '0;
            r_side2 <= '0;
            r_side3 <= '0;
        end else begin
            r_side1 <= c_side[QW];
            r_side2 <= r_side1;
            r_side3 <= r_side2;
        end
    end

    // ---------------- quadrant fix-up and clamp ----------------
    logic signed [11:0] ang_a, ang_b;
    logic [atan_pkg::ANG_W-1:0] n_angle;

    always_comb begin
        if (r_side3.y_zero) begin
            ang_a = r_side3.x_neg ? 12'(atan_pkg::C_HALF) : 12'sd0;
        end else begin
            ang_a = (r_side3.x_neg ? 12'(atan_pkg::C_HI) : 12'(atan_pkg::C_LO))
                  + 12'(r_t);
        end
        ang_b = r_side3.y_neg ? (12'(atan_pkg::C_FULL) - ang_a) : ang_a;
        if (ang_b < 12'sd0) begin
            n_angle = '0;
        end else if (ang_b > 12'(atan_pkg::C_FULL)) begin
            n_angle = atan_pkg::ANG_W'(atan_pkg::C_FULL);
        end else begin
            n_angle = ang_b[atan_pkg::ANG_W-1:0];
        end
    end

    logic                       r_done;
    logic [atan_pkg::ANG_W-1:0] r_angle;

    always_ff @(posedge i_clk) begin
        r_angle <= n_angle;
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_side3.vld;
        end
    end

    assign o_done          = r_done;
    assign o_angle_degrees = r_angle;

    // ---------------- assertions ----------------
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_angle_degrees <= atan_pkg::ANG_W'(atan_pkg::C_FULL)))
        else $error("angle out of range");

    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |-> ##LAT o_done)
        else $error("result missing after pipeline latency");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && i_y_value == '0 && !i_x_value[atan_pkg::IN_W-1])
            |-> ##LAT (o_done && o_angle_degrees == '0))
        else $error("zero y with nonnegative x must give 0");

    a_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (c_side[QW].vld && !c_side[QW].y_zero) |-> (c_quo[QW] <= QW'(1 << FRAC_BITS)))
        else $error("ratio magnitude exceeds one");

endmodule
